FILE: rtl/lfbs_pkg.sv
package lfbs_pkg;

  localparam int LED_COUNT = 16;
  localparam int WORD_W    = 16;
  localparam int POS_W     = 4;

  localparam logic [POS_W-1:0]  POS_LAST     = 4'd15;
  localparam logic [WORD_W-1:0] PERIOD_RESET = 16'd15;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_STEADY = 2'd1,
    ACT_FLASH  = 2'd2,
    ACT_BLINK  = 2'd3
  } lfbs_action_t;

  // word queue status seen by the two sides
  typedef struct packed {
    logic full;
    logic empty;
  } lfbs_q_stat_t;

  // shift position i carries word bit (15 - SHIFT_ORDER[i])
  localparam logic [POS_W-1:0] SHIFT_ORDER [LED_COUNT] = '{
    4'd14, 4'd13, 4'd12, 4'd11, 4'd10, 4'd9, 4'd8, 4'd15,
    4'd6,  4'd5,  4'd4,  4'd3,  4'd2,  4'd1, 4'd0, 4'd7
  };

  // reorder a display word into shift order, bit 0 goes out first
  function automatic logic [WORD_W-1:0] shift_perm(input logic [WORD_W-1:0] word);
    logic [WORD_W-1:0] res;
    res = '0;
    for (int i = 0; i < LED_COUNT; i++) begin
      res[i] = word[POS_LAST - SHIFT_ORDER[i]];
    end
    return res;
  endfunction

endpackage

FILE: rtl/lfbs_front.sv
module lfbs_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [15:0]                 cfg_wr_data,
  input  logic                        in_push,
  input  logic [1:0]                  in_action,
  input  logic [15:0]                 in_value,
  input  lfbs_pkg::lfbs_q_stat_t      q_stat,
  output logic                        q_push,
  output logic [lfbs_pkg::WORD_W-1:0] q_word
);
  import lfbs_pkg::*;

  logic [WORD_W-1:0] period_r, period_nxt;
  logic [WORD_W-1:0] steady_r, steady_nxt;
  logic [WORD_W-1:0] flash_r, flash_nxt;
  logic [WORD_W-1:0] blink_r, blink_nxt;
  logic [WORD_W-1:0] cnt_r, cnt_nxt;
  logic              phase_r, phase_nxt;
  logic [WORD_W-1:0] cnt_inc;
  logic              accept;

  assign accept  = in_push && !q_stat.full;
  assign cnt_inc = cnt_r + 16'd1;
  assign q_word  = (steady_r | (phase_r ? flash_r : '0)) ^ blink_r;

  always_comb begin
    period_nxt = cfg_wr_en ? cfg_wr_data : period_r;
    steady_nxt = steady_r;
    flash_nxt  = flash_r;
    blink_nxt  = blink_r;
    cnt_nxt    = cnt_r;
    phase_nxt  = phase_r;
    q_push     = 1'b0;
    if (accept) begin
      case (lfbs_action_t'(in_action))
        ACT_TICK: begin
          q_push    = 1'b1;
          blink_nxt = '0;
          if (cnt_inc == period_r) begin
            cnt_nxt   = '0;
            phase_nxt = !phase_r;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
        ACT_STEADY: steady_nxt = in_value;
        ACT_FLASH: begin
          flash_nxt = in_value;
          cnt_nxt   = '0;
          phase_nxt = 1'b1;
        end
        ACT_BLINK: blink_nxt = in_value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
      steady_r <= '0;
      flash_r  <= '0;
      blink_r  <= '0;
      cnt_r    <= '0;
      phase_r  <= 1'b1;
    end else begin
      period_r <= period_nxt;
      steady_r <= steady_nxt;
      flash_r  <= flash_nxt;
      blink_r  <= blink_nxt;
      cnt_r    <= cnt_nxt;
      phase_r  <= phase_nxt;
    end
  end

endmodule

FILE: rtl/lfbs_word_q.sv
module lfbs_word_q #(
  parameter int DEPTH = 2
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  logic [lfbs_pkg::WORD_W-1:0] push_word,
  input  logic                        pop,
  output logic [lfbs_pkg::WORD_W-1:0] head_word,
  output lfbs_pkg::lfbs_q_stat_t      stat
);
  import lfbs_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [WORD_W-1:0] mem_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;

  assign head_word  = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == CNT_FULL);
  assign stat.empty = (cnt_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/lfbs_back.sv
module lfbs_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [lfbs_pkg::WORD_W-1:0] q_word,
  input  lfbs_pkg::lfbs_q_stat_t      q_stat,
  output logic                        q_pop,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic                        out_ser_bit,
  output logic [3:0]                  out_bit_position,
  output logic                        out_latch
);
  import lfbs_pkg::*;

  logic [WORD_W-1:0] word_r, word_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              busy_r, busy_nxt;
  logic              ov_r, ov_nxt;
  logic              obit_r, obit_nxt;
  logic [POS_W-1:0]  opos_r, opos_nxt;
  logic              olatch_r, olatch_nxt;
  logic              slot;
  logic [WORD_W-1:0] perm;

  assign slot = !ov_r || out_pop;
  assign perm = shift_perm(q_word);

  assign out_empty        = !ov_r;
  assign out_ser_bit      = obit_r;
  assign out_bit_position = opos_r;
  assign out_latch        = olatch_r;

  always_comb begin
    word_nxt   = word_r;
    pos_nxt    = pos_r;
    busy_nxt   = busy_r;
    ov_nxt     = ov_r;
    obit_nxt   = obit_r;
    opos_nxt   = opos_r;
    olatch_nxt = olatch_r;
    q_pop      = 1'b0;
    if (slot) begin
      if (busy_r) begin
        obit_nxt   = word_r[pos_r];
        opos_nxt   = pos_r;
        olatch_nxt = (pos_r == POS_LAST);
        ov_nxt     = 1'b1;
        pos_nxt    = pos_r + 1'b1;
        busy_nxt   = (pos_r != POS_LAST);
      end else if (!q_stat.empty) begin
        // first bit goes straight from the queue head
        q_pop      = 1'b1;
        word_nxt   = perm;
        obit_nxt   = perm[0];
        opos_nxt   = '0;
        olatch_nxt = 1'b0;
        ov_nxt     = 1'b1;
        pos_nxt    = 4'd1;
        busy_nxt   = 1'b1;
      end else begin
        ov_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r   <= word_nxt;
    obit_r   <= obit_nxt;
    opos_r   <= opos_nxt;
    olatch_r <= olatch_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
  end

endmodule

FILE: rtl/led_flash_blink_serializer_unit.sv
// Serial driver for 16 LEDs on two cascaded latching shift registers. Write
// in_action/in_value through a queue-style port (push/full): a set action
// (steady, flash, blink) updates the stored pattern and makes no output; a
// flash write also restarts the flash phase as on. A tick forms (steady |
// (phase & flash)) ^ blink, clears the blink mask and queues the word. The
// back end drains the queue and presents one serial bit per cycle while
// popped on a queue-style result port (empty/pop), positions 0..15 in shift
// order, with out_latch set on position 15. A tick therefore costs 16
// result transfers; the serializer's single output register sets that rate,
// and the word queue (WORD_Q_DEPTH ticks) lets new items be taken while a
// word is still shifting out. cfg_wr_data sets the number of ticks between
// flash phase toggles (reset 15); write it only when idle.
module led_flash_blink_serializer_unit #(
  parameter int WORD_Q_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  // item input
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_value,
  // serial bit output
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_ser_bit,
  output logic [3:0]  out_bit_position,
  output logic        out_latch
);
  import lfbs_pkg::*;

  lfbs_q_stat_t      q_stat;
  logic              q_push;
  logic              q_pop;
  logic [WORD_W-1:0] q_push_word;
  logic [WORD_W-1:0] q_head_word;

  // front stalls only when the word queue is full
  assign in_full = q_stat.full;

  lfbs_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_push     (in_push),
    .in_action   (in_action),
    .in_value    (in_value),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_word      (q_push_word)
  );

  lfbs_word_q #(
    .DEPTH (WORD_Q_DEPTH)
  ) u_word_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (q_push_word),
    .pop       (q_pop),
    .head_word (q_head_word),
    .stat      (q_stat)
  );

  lfbs_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_word           (q_head_word),
    .q_stat           (q_stat),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_ser_bit      (out_ser_bit),
    .out_bit_position (out_bit_position),
    .out_latch        (out_latch)
  );

endmodule
